### rtl/core/squared_hinge_loss_gradient_macros.svh
// squared_hinge_loss_gradient_macros.svh: assertion macros for the squared hinge
// loss gradient block. Expects clk and rst in the scope of each use.
`ifndef SQUARED_HINGE_LOSS_GRADIENT_MACROS_SVH
`define SQUARED_HINGE_LOSS_GRADIENT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define SHLG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define SHLG_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SHLG_ASSERT(label, prop, msg)
`define SHLG_ASSERT_NEVER(label, cond, msg)
`endif
`endif

### rtl/core/shlg_pkg.sv
`timescale 1ns / 1ps
// shlg_pkg: widths, squaring step codes and the command/status types shared by
// the squared hinge loss gradient controller, datapath and top level. No dependencies.
package shlg_pkg;

  localparam int SAMPLE_WIDTH     = 16;  // Q4.12 samples
  localparam int ITEM_MAX_DEFAULT = 64;
  localparam int DOT_WIDTH        = 40;  // Q.24 dot product
  localparam int LOSS_WIDTH       = 47;  // Q.24 loss total
  localparam int GRAD_WIDTH       = 32;  // Q.12 gradient
  localparam int DIFF_WIDTH       = 41;  // 1 - v, Q.24
  localparam int FRAC_BITS        = 24;
  localparam int SQ_HALF          = 18;  // squaring operand half width

  localparam int S_TDATA_WIDTH = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_WIDTH = ((GRAD_WIDTH + LOSS_WIDTH + 7) / 8) * 8;
  localparam int M_TUSER_WIDTH = 3;

  localparam logic [0:0] REG_GRADIENT_ENABLE = 1'b0;

  // Partial product steps of the loss square
  localparam logic [1:0] SQ_HH  = 2'd0;
  localparam logic [1:0] SQ_HL  = 2'd1;
  localparam logic [1:0] SQ_LL  = 2'd2;
  localparam logic [1:0] SQ_END = 2'd3;

  typedef struct packed {
    logic       in_ready;
    logic       form_diff;
    logic       sq_en;
    logic [1:0] sq_step;
    logic       loss_update;
    logic       issue;
    logic       item_clear;
  } cmd_t;

  typedef struct packed {
    logic end_offered;  // an item-closing beat is on the input
    logic issue_last;   // the entry being issued is the last of the run
    logic last_out;     // the last result moves into the output register
  } sts_t;

endpackage

### rtl/core/shlg_ctrl.sv
`timescale 1ns / 1ps
// shlg_ctrl: sequencer for the squared hinge loss gradient block.
// Depends on shlg_pkg for the command and status types.
module shlg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  shlg_pkg::sts_t  sts,
  output shlg_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DOT    = 4'd1;
  localparam logic [3:0] S_DIFF   = 4'd2;
  localparam logic [3:0] S_SQ_HH  = 4'd3;
  localparam logic [3:0] S_SQ_HL  = 4'd4;
  localparam logic [3:0] S_SQ_LL  = 4'd5;
  localparam logic [3:0] S_SQ_END = 4'd6;
  localparam logic [3:0] S_LOSS   = 4'd7;
  localparam logic [3:0] S_ISSUE  = 4'd8;
  localparam logic [3:0] S_DRAIN  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.end_offered) begin
          state_next = S_DOT;
        end
      end
      // let the final product settle into the accumulator
      S_DOT: begin
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.form_diff = 1'b1;
        state_next    = S_SQ_HH;
      end
      S_SQ_HH: begin
        cmd.sq_en   = 1'b1;
        cmd.sq_step = shlg_pkg::SQ_HH;
        state_next  = S_SQ_HL;
      end
      S_SQ_HL: begin
        cmd.sq_en   = 1'b1;
        cmd.sq_step = shlg_pkg::SQ_HL;
        state_next  = S_SQ_LL;
      end
      S_SQ_LL: begin
        cmd.sq_en   = 1'b1;
        cmd.sq_step = shlg_pkg::SQ_LL;
        state_next  = S_SQ_END;
      end
      S_SQ_END: begin
        cmd.sq_en   = 1'b1;
        cmd.sq_step = shlg_pkg::SQ_END;
        state_next  = S_LOSS;
      end
      S_LOSS: begin
        cmd.loss_update = 1'b1;
        state_next      = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.last_out) begin
          cmd.item_clear = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/shlg_datapath.sv
`timescale 1ns / 1ps
// shlg_datapath: dot product accumulator, expected-value store, loss squaring
// and gradient pipeline. Depends on shlg_pkg and the assertion macro header.
`include "squared_hinge_loss_gradient_macros.svh"

module shlg_datapath #(
  parameter int ITEM_MAX = shlg_pkg::ITEM_MAX_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  shlg_pkg::cmd_t                             cmd,
  output shlg_pkg::sts_t                             sts,
  input  logic                                       gradient_enable,
  input  logic                                       in_valid,
  input  logic signed [shlg_pkg::SAMPLE_WIDTH-1:0]   actual_value,
  input  logic signed [shlg_pkg::SAMPLE_WIDTH-1:0]   expected_value,
  input  logic                                       end_of_item,
  input  logic                                       end_of_batch,
  input  logic                                       out_ready,
  output logic                                       out_valid,
  output logic        [shlg_pkg::GRAD_WIDTH-1:0]     gradient_value,
  output logic                                       gradient_valid,
  output logic                                       last_of_run,
  output logic        [shlg_pkg::LOSS_WIDTH-1:0]     loss_total,
  output logic                                       loss_valid,
  output logic                                       item_overflow
);

  localparam int SW   = shlg_pkg::SAMPLE_WIDTH;
  localparam int DW   = shlg_pkg::DOT_WIDTH;
  localparam int DW1  = DW + 1;
  localparam int LW   = shlg_pkg::LOSS_WIDTH;
  localparam int LW1  = LW + 1;
  localparam int GW   = shlg_pkg::GRAD_WIDTH;
  localparam int XW   = shlg_pkg::DIFF_WIDTH;
  localparam int FB   = shlg_pkg::FRAC_BITS;
  localparam int HW   = shlg_pkg::SQ_HALF;
  localparam int SQW  = 4 * HW;
  localparam int PW   = 2 * SW;
  localparam int PHW  = XW - FB + SW;
  localparam int PLW  = FB + SW;
  localparam int PGW  = XW + SW;
  localparam int MW   = PGW - (FB - 1);
  localparam int CW   = $clog2(ITEM_MAX + 1);
  localparam int AW   = (ITEM_MAX > 1) ? $clog2(ITEM_MAX) : 1;

  localparam logic signed [DW-1:0] ONE_Q    = DW'(1) << FB;
  localparam logic        [LW-1:0] LOSS_MAX = '1;
  localparam logic        [GW-1:0] GRAD_MAX = {1'b0, {(GW - 1){1'b1}}};
  localparam logic        [GW-1:0] GRAD_MIN = {1'b1, {(GW - 1){1'b0}}};

  // control state
  logic                  accept;
  logic                  adv;
  logic signed [DW-1:0]  acc;
  logic        [LW-1:0]  loss_acc;
  logic        [CW-1:0]  count;
  logic                  overflow;
  logic                  p_valid;
  logic                  batch_end;
  logic        [CW-1:0]  idx;
  logic                  a_valid;
  logic                  b_valid;

  // payload
  logic [SW-1:0]         store [ITEM_MAX];
  logic signed [PW-1:0]  p_reg;
  logic [XW-1:0]         d;
  logic [2*HW-1:0]       pp;
  logic [SQW-1:0]        sq;
  logic signed [SW-1:0]  rd;
  logic                  a_last;
  logic                  a_grad;
  logic                  b_last;
  logic                  b_grad;
  logic                  b_neg;
  logic [PHW-1:0]        ph;
  logic [PLW-1:0]        pl;

  // combinational
  logic signed [DW1-1:0] dot_sum;
  logic signed [DW-1:0]  dot_sat;
  logic signed [XW-1:0]  diff;
  logic [HW-1:0]         sq_h;
  logic [HW-1:0]         sq_l;
  logic                  loss_over;
  logic [LW-1:0]         term;
  logic [LW1-1:0]        loss_sum;
  logic [LW-1:0]         loss_next;
  logic                  idx_last;
  logic [SW-1:0]         ae;
  logic [PGW-1:0]        pg;
  logic [MW-1:0]         mag;
  logic [GW-1:0]         mag_lo;
  logic                  mag_big;
  logic [GW-1:0]         g_sat;

  assign accept = in_valid && cmd.in_ready;
  assign adv    = !out_valid || out_ready;

  // dot product, saturating at the accumulator width
  assign dot_sum = DW1'(acc) + DW1'(p_reg);
  always_comb begin
    if (dot_sum[DW] != dot_sum[DW-1]) begin
      dot_sat = dot_sum[DW] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
    end else begin
      dot_sat = dot_sum[DW-1:0];
    end
  end

  assign diff = XW'(ONE_Q) - XW'(acc);

  // loss term: floor(d^2 / 2^24), saturated
  assign sq_h      = d[2*HW-1:HW];
  assign sq_l      = d[HW-1:0];
  assign loss_over = (|d[XW-1:2*HW]) || sq[SQW-1];
  assign term      = loss_over ? LOSS_MAX : sq[FB +: LW];
  assign loss_sum  = {1'b0, loss_acc} + {1'b0, term};
  assign loss_next = loss_sum[LW] ? LOSS_MAX : loss_sum[LW-1:0];

  // gradient: -2 * d * e, Q.12, saturated
  assign idx_last = !gradient_enable || (CW'(idx + 1'b1) == count);
  assign ae       = rd[SW-1] ? (~rd + 1'b1) : rd;
  assign pg       = (PGW'(ph) << FB) + PGW'(pl);
  assign mag      = pg[PGW-1:FB-1];
  assign mag_big  = |mag[MW-1:GW-1];
  assign mag_lo   = {1'b0, mag[GW-2:0]};
  always_comb begin
    if (b_neg) begin
      g_sat = mag_big ? GRAD_MIN : (~mag_lo + 1'b1);
    end else begin
      g_sat = mag_big ? GRAD_MAX : mag_lo;
    end
  end

  assign sts.end_offered = in_valid && (end_of_item || end_of_batch);
  assign sts.issue_last  = adv && idx_last;
  assign sts.last_out    = adv && b_valid && b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      loss_acc  <= '0;
      count     <= '0;
      overflow  <= 1'b0;
      p_valid   <= 1'b0;
      batch_end <= 1'b0;
      idx       <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid <= accept;
      if (accept) begin
        batch_end <= end_of_batch;
        if (count < CW'(ITEM_MAX)) begin
          count <= count + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
      if (p_valid) begin
        acc <= dot_sat;
      end
      if (cmd.loss_update) begin
        loss_acc <= loss_next;
      end
      // advance the result pipeline only when the output register frees up
      if (adv) begin
        a_valid   <= cmd.issue;
        b_valid   <= a_valid;
        out_valid <= b_valid;
      end
      if (cmd.issue && adv) begin
        idx <= idx + 1'b1;
      end
      if (cmd.item_clear) begin
        acc      <= '0;
        count    <= '0;
        overflow <= 1'b0;
        idx      <= '0;
        if (batch_end) begin
          loss_acc <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (count < CW'(ITEM_MAX))) begin
      store[count[AW-1:0]] <= expected_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_reg <= actual_value * expected_value;
    end
    if (cmd.form_diff) begin
      d <= (acc < ONE_Q) ? XW'(diff) : '0;
    end
    if (cmd.sq_en) begin
      unique case (cmd.sq_step)
        shlg_pkg::SQ_HH: begin
          pp <= sq_h * sq_h;
          sq <= '0;
        end
        shlg_pkg::SQ_HL: begin
          pp <= sq_h * sq_l;
          sq <= sq + (SQW'(pp) << (2 * HW));
        end
        shlg_pkg::SQ_LL: begin
          pp <= sq_l * sq_l;
          sq <= sq + (SQW'(pp) << (HW + 1));
        end
        shlg_pkg::SQ_END: begin
          sq <= sq + SQW'(pp);
        end
      endcase
    end
    if (adv) begin
      a_last         <= idx_last;
      a_grad         <= gradient_enable;
      rd             <= store[idx[AW-1:0]];
      b_last         <= a_last;
      b_grad         <= a_grad;
      b_neg          <= !rd[SW-1] && (rd != '0);
      ph             <= d[XW-1:FB] * ae;
      pl             <= d[FB-1:0] * ae;
      gradient_value <= b_grad ? g_sat : '0;
      gradient_valid <= b_grad;
      last_of_run    <= b_last;
      loss_valid     <= b_last && batch_end;
      loss_total     <= (b_last && batch_end) ? loss_acc : '0;
      item_overflow  <= overflow;
    end
  end

  `SHLG_ASSERT_NEVER(a_accept_while_busy, accept && (a_valid || b_valid), "beat taken with results in flight")
  `SHLG_ASSERT(a_overflow_full, overflow |-> (count == CW'(ITEM_MAX)), "overflow flagged below store depth")
  `SHLG_ASSERT(a_issue_in_range, (cmd.issue && gradient_enable) |-> (idx < count), "store read past last element")

endmodule

### rtl/core/squared_hinge_loss_gradient.sv
`timescale 1ns / 1ps
// squared_hinge_loss_gradient: top level with the APB register, the sequencer and
// the datapath. Depends on shlg_pkg, shlg_ctrl and shlg_datapath.
//
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------------------
//  s_*      | in        | element pair, tlast ends the item, tuser ends the batch
//  m_*      | out       | gradient and/or loss result, tlast on the run's final beat
//  APB      | in/out    | gradient_enable at word 0
//
// Inside an item an element beat is taken every cycle; its 16x16 product is registered
// and folded into the 40-bit accumulator the cycle after. The closing beat starts the
// loss work (settle, form 1 - v, four steps through one 18x18 multiplier, loss update).
// Results then leave one per cycle through a three-register pipeline:
// n in gradient mode, one otherwise; the next item is taken once the last one sits in
// the output register. Reset is synchronous; a stall on m_tready holds the pipeline.
module squared_hinge_loss_gradient #(
  parameter int ITEM_MAX = shlg_pkg::ITEM_MAX_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [shlg_pkg::S_TDATA_WIDTH-1:0]  s_tdata,   // actual_value, expected_value
  input  logic                                s_tlast,   // end_of_item
  input  logic [0:0]                          s_tuser,   // end_of_batch
  // master stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [shlg_pkg::M_TDATA_WIDTH-1:0]  m_tdata,   // gradient_value, loss_total, pad
  output logic                                m_tlast,   // last_of_run
  output logic [shlg_pkg::M_TUSER_WIDTH-1:0]  m_tuser,   // gradient_valid, loss_valid,
                                                         // item_overflow
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int SW = shlg_pkg::SAMPLE_WIDTH;

  shlg_pkg::cmd_t                  cmd;
  shlg_pkg::sts_t                  sts;
  logic                            gradient_enable;
  logic                            cfg_write;
  logic [shlg_pkg::GRAD_WIDTH-1:0] gradient_value;
  logic [shlg_pkg::LOSS_WIDTH-1:0] loss_total;
  logic                            gradient_valid;
  logic                            loss_valid;
  logic                            item_overflow;

  // Register file: one word, decoded on the word address bit
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_enable <= 1'b0;
    end else if (cfg_write && (paddr[2:2] == shlg_pkg::REG_GRADIENT_ENABLE)) begin
      gradient_enable <= pwdata[0];
    end
  end

  assign prdata = (paddr[2:2] == shlg_pkg::REG_GRADIENT_ENABLE) ?
                  {31'b0, gradient_enable} : '0;

  shlg_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  assign s_tready = cmd.in_ready;

  shlg_datapath #(
    .ITEM_MAX (ITEM_MAX)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .gradient_enable (gradient_enable),
    .in_valid        (s_tvalid),
    .actual_value    (s_tdata[SW-1:0]),
    .expected_value  (s_tdata[2*SW-1:SW]),
    .end_of_item     (s_tlast),
    .end_of_batch    (s_tuser[0]),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .gradient_value  (gradient_value),
    .gradient_valid  (gradient_valid),
    .last_of_run     (m_tlast),
    .loss_total      (loss_total),
    .loss_valid      (loss_valid),
    .item_overflow   (item_overflow)
  );

  // Pack the result beat, lowest field first
  assign m_tdata = shlg_pkg::M_TDATA_WIDTH'({loss_total, gradient_value});
  assign m_tuser = {item_overflow, loss_valid, gradient_valid};

endmodule

### tb/shlg_checker.sv
`timescale 1ns / 1ps
// shlg_checker: watches the element, result and APB channels of the squared hinge
// loss gradient block, predicts each result beat and compares it. Depends on shlg_pkg.
module shlg_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [shlg_pkg::S_TDATA_WIDTH-1:0] s_tdata,   // actual_value, expected_value
  input  logic                               s_tlast,   // end_of_item
  input  logic [0:0]                         s_tuser,   // end_of_batch
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [shlg_pkg::M_TDATA_WIDTH-1:0] m_tdata,   // gradient_value, loss_total, pad
  input  logic                               m_tlast,   // last_of_run
  input  logic [shlg_pkg::M_TUSER_WIDTH-1:0] m_tuser,   // gradient_valid, loss_valid,
                                                        // item_overflow
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  input  logic                               pready,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 results_checked,
  output int                                 batches_closed
);

  localparam int GW = shlg_pkg::GRAD_WIDTH;
  localparam int LW = shlg_pkg::LOSS_WIDTH;
  localparam int FB = shlg_pkg::FRAC_BITS;
  localparam int IM = shlg_pkg::ITEM_MAX_DEFAULT;
  localparam longint DOT_HI = (longint'(1) <<< (shlg_pkg::DOT_WIDTH - 1)) - 1;
  localparam longint DOT_LO = -(longint'(1) <<< (shlg_pkg::DOT_WIDTH - 1));
  localparam longint UNITY = longint'(1) <<< FB;
  localparam logic [LW-1:0] LOSS_CEIL = '1;

  typedef struct {
    logic signed [GW-1:0] gradient;
    logic                 gradient_valid;
    logic                 last_of_run;
    logic [LW-1:0]        loss_total;
    logic                 loss_valid;
    logic                 item_overflow;
  } hinge_result_t;

  bit                                       grad_mode;
  longint                                   dot_sum;
  logic [LW-1:0]                            loss_sum;
  logic signed [shlg_pkg::SAMPLE_WIDTH-1:0] target_store [IM];
  int                                       stored;
  bit                                       too_long;
  hinge_result_t                            result_q [$];

  // floor((1 - v)^2) in Q.24, clamped to the loss width
  function automatic logic [LW-1:0] hinge_square(longint gap);
    logic [127:0] sq;
    sq = (128'(gap) * 128'(gap)) >> FB;
    return (sq > 128'(LOSS_CEIL)) ? LOSS_CEIL : sq[LW-1:0];
  endfunction

  // -2 (1 - v) e in Q.12: magnitude truncated, then sign, then 32-bit clamp
  function automatic logic signed [GW-1:0] hinge_slope(longint gap,
                                                    logic signed [15:0] target);
    longint mag;
    longint val;
    mag = (2 * gap * (target < 0 ? -longint'(target) : longint'(target))) >>> FB;
    val = (target > 0) ? -mag : mag;
    if (val > longint'(32'sh7FFFFFFF)) val = longint'(32'sh7FFFFFFF);
    if (val < -longint'(64'h80000000)) val = -longint'(64'h80000000);
    return val[GW-1:0];
  endfunction

  task automatic take_pair(logic [31:0] data, bit item_last, bit batch_last);
    logic signed [15:0]    actual;
    logic signed [15:0]    target;
    longint                sum;
    longint                gap;
    logic [LW:0]           wide;
    int                    runs;
    hinge_result_t         r;
    actual = data[15:0];
    target = data[31:16];
    sum = dot_sum + longint'(actual) * longint'(target);
    if (sum > DOT_HI) sum = DOT_HI;
    if (sum < DOT_LO) sum = DOT_LO;
    dot_sum = sum;
    if (stored < IM) begin
      target_store[stored] = target;
      stored++;
    end else begin
      too_long = 1'b1;
    end
    if (!(item_last || batch_last)) return;

    gap = 0;
    if (dot_sum < UNITY) begin
      gap = UNITY - dot_sum;
      wide = {1'b0, loss_sum} + {1'b0, hinge_square(gap)};
      loss_sum = (wide > {1'b0, LOSS_CEIL}) ? LOSS_CEIL : wide[LW-1:0];
    end

    // one beat in loss-only mode, one per stored element in gradient mode
    runs = grad_mode ? stored : 0;
    for (int k = 0; k < (runs > 0 ? runs : 1); k++) begin
      r.last_of_run    = (k == (runs > 0 ? runs : 1) - 1);
      r.gradient_valid = (runs > 0);
      r.gradient       = (runs > 0 && gap != 0) ? hinge_slope(gap, target_store[k]) : '0;
      r.loss_valid     = r.last_of_run && batch_last;
      r.loss_total     = r.loss_valid ? loss_sum : '0;
      r.item_overflow  = too_long;
      result_q.push_back(r);
    end

    dot_sum  = 0;
    stored   = 0;
    too_long = 1'b0;
    if (batch_last) begin
      loss_sum = '0;
      batches_closed++;
    end
  endtask

  task automatic flag_field(string field, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic check_beat();
    hinge_result_t want;
    if (result_q.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with nothing expected, expected none, got tdata %h",
               $time, m_tdata);
      return;
    end
    want = result_q.pop_front();
    results_checked++;
    flag_field("gradient_value", longint'(want.gradient),
               longint'($signed(m_tdata[GW-1:0])));
    flag_field("loss_total", longint'(want.loss_total),
               longint'(m_tdata[GW +: LW]));
    flag_field("gradient_valid", want.gradient_valid, m_tuser[0]);
    flag_field("loss_valid", want.loss_valid, m_tuser[1]);
    flag_field("item_overflow", want.item_overflow, m_tuser[2]);
    flag_field("last_of_run", want.last_of_run, m_tlast);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      grad_mode       = 1'b0;
      dot_sum         = 0;
      loss_sum        = '0;
      stored          = 0;
      too_long        = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      batches_closed  = 0;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == {shlg_pkg::REG_GRADIENT_ENABLE, 2'b00})
        grad_mode = pwdata[0];
      if (s_tvalid && s_tready) take_pair(s_tdata[31:0], s_tlast, s_tuser[0]);
      if (m_tvalid && m_tready) check_beat();
    end
    pending = result_q.size();
  end

endmodule

### tb/squared_hinge_loss_gradient_tb.sv
`timescale 1ns / 1ps
// squared_hinge_loss_gradient_tb: stimulus and verdict for the squared hinge loss
// gradient block. Depends on shlg_pkg, shlg_checker and the block itself.
module squared_hinge_loss_gradient_tb;

  // Flavours of element pair drawn for one item
  typedef enum int {
    PAIR_RANDOM,
    PAIR_SMALL,
    PAIR_ALIGNED,
    PAIR_OPPOSED,
    PAIR_EXTREME
  } pair_style_e;

  localparam logic [2:0] ADDR_GRADIENT_ENABLE = {shlg_pkg::REG_GRADIENT_ENABLE, 2'b00};
  localparam int         IM                   = shlg_pkg::ITEM_MAX_DEFAULT;

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [shlg_pkg::S_TDATA_WIDTH-1:0] s_tdata;    // actual_value, expected_value
  logic                               s_tlast;    // end_of_item
  logic [0:0]                         s_tuser;    // end_of_batch
  logic                               m_tvalid;
  logic                               m_tready;
  logic [shlg_pkg::M_TDATA_WIDTH-1:0] m_tdata;    // gradient_value, loss_total, pad
  logic                               m_tlast;    // last_of_run
  logic [shlg_pkg::M_TUSER_WIDTH-1:0] m_tuser;    // gradient_valid, loss_valid,
                                                  // item_overflow
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [2:0]                         paddr;
  logic [31:0]                        pwdata;
  logic [31:0]                        prdata;
  logic                               pready;

  int mismatches;
  int pending;
  int results_checked;
  int batches_closed;
  int beats_sent;
  bit steady_tx;   // no gaps between element beats while set
  bit steady_rx;   // no stalls on the result side while set

  squared_hinge_loss_gradient uut (.*);

  shlg_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .pending, .results_checked, .batches_closed
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous ceiling: far above the slowest legal run with every gap and stall
  initial begin
    #5_000_000;
    $display("squared_hinge_loss_gradient_tb failed");
    $finish;
  end

  // Result side: draw a stall before each beat, then hold tready until one moves
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady_rx ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic logic [15:0] small_sample();
    return 16'($urandom_range(0, 32'h2000)) - 16'h1000;
  endfunction

  function automatic logic [15:0] corner_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h1000;
      4: return 16'hFFFF;
      default: return 16'hF000;
    endcase
  endfunction

  // Offer one element beat after a drawn gap and hold it until accepted.
  // Valid is only lowered when a gap follows, never in the step it is raised.
  task automatic send_pair(logic [15:0] actual, logic [15:0] target, bit item_last,
                           bit batch_last);
    int gap;
    gap = steady_tx ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {target, actual};
    s_tlast  <= item_last;
    s_tuser  <= batch_last;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  task automatic send_repeat(logic [15:0] actual, logic [15:0] target, int count,
                             bit batch_last);
    for (int i = 0; i < count; i++)
      send_pair(actual, target, i == count - 1, (i == count - 1) && batch_last);
  endtask

  // One item of len pairs; a batch end closes it with or without tlast
  task automatic send_item(int len, pair_style_e style, bit batch_last);
    logic [15:0] actual;
    logic [15:0] target;
    bit          tlast_too;
    bit          closing;
    tlast_too = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      case (style)
        PAIR_RANDOM: begin
          actual = 16'($urandom);
          target = 16'($urandom);
        end
        PAIR_SMALL: begin
          actual = small_sample();
          target = small_sample();
        end
        PAIR_ALIGNED: begin
          target = $urandom_range(0, 1) ? 16'($urandom) : small_sample();
          actual = target;
        end
        PAIR_OPPOSED: begin
          target = $urandom_range(0, 1) ? 16'($urandom) : small_sample();
          actual = -target;
        end
        default: begin
          actual = corner_sample();
          target = corner_sample();
        end
      endcase
      closing = (i == len - 1);
      send_pair(actual, target, closing && (!batch_last || tlast_too),
                closing && batch_last);
    end
  endtask

  // Drop valid, wait for every predicted beat, then let the loss pipeline settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(int beat_goal);
    int len;
    while (beats_sent < beat_goal) begin
      steady_tx = ($urandom_range(0, 5) == 0);
      steady_rx = ($urandom_range(0, 5) == 0);
      // mostly short items, now and then a longer one that may run past the store depth
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
      send_item(len, pair_style_e'($urandom_range(0, 4)), $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) drain_results();
    end
  endtask

  initial begin
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tlast    <= 1'b0;
    s_tuser    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    beats_sent = 0;
    steady_tx  = 1'b0;
    steady_rx  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Loss-only mode straight out of reset
    send_pair(16'h0000, 16'h0000, 1'b1, 1'b0);   // v = 0, full unit loss
    send_pair(16'h1000, 16'h1000, 1'b1, 1'b0);   // v = 1 exactly, no loss term
    send_pair(16'h8000, 16'h7FFF, 1'b0, 1'b0);
    send_pair(16'h7FFF, 16'h7FFF, 1'b1, 1'b1);   // batch closes with its loss
    send_pair(16'h7FFF, 16'h8000, 1'b0, 1'b1);   // batch end with no item end

    drain_results();
    apb_write(ADDR_GRADIENT_ENABLE, 32'd1);

    // Gradient mode: sign and magnitude extremes of the target
    send_pair(16'h1234, 16'h8000, 1'b0, 1'b0);
    send_pair(16'h0001, 16'h7FFF, 1'b0, 1'b0);
    send_pair(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_pair(16'h8000, 16'hFFFF, 1'b1, 1'b0);
    send_pair(16'h7FFF, 16'h7FFF, 1'b1, 1'b0);   // v >= 1, zero gradients
    send_pair(16'h0800, 16'hF000, 1'b0, 1'b1);   // batch end closes the item

    // Store exactly full, then one element past it
    send_item(IM, PAIR_SMALL, 1'b0);
    send_item(IM + 1, PAIR_SMALL, 1'b1);

    // Long runs of extremes that spill past the store: the opposed one also
    // saturates the loss term, the aligned one leaves v far above one
    steady_tx = 1'b1;
    send_repeat(16'h8000, 16'h7FFF, 70, 1'b1);
    send_repeat(16'h8000, 16'h8000, 70, 1'b1);
    steady_tx = 1'b0;

    // Random traffic across both modes, idle between register writes
    drain_results();
    random_phase(beats_sent + 45);
    drain_results();
    apb_write(ADDR_GRADIENT_ENABLE, 32'd0);
    random_phase(beats_sent + 45);
    drain_results();
    apb_write(ADDR_GRADIENT_ENABLE, 32'd1);
    random_phase(beats_sent + 45);

    steady_tx = 1'b0;
    steady_rx = 1'b0;
    drain_results();

    $display("run covered %0d element beats and %0d result beats over %0d batches,",
             beats_sent, results_checked, batches_closed);
    $display("in loss-only and gradient modes, with store overflow and saturation");
    if (mismatches == 0 && pending == 0) begin
      $display("squared_hinge_loss_gradient_tb passed");
    end else begin
      $display("squared_hinge_loss_gradient_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/shlg_pkg.sv
rtl/core/shlg_ctrl.sv
rtl/core/shlg_datapath.sv
rtl/core/squared_hinge_loss_gradient.sv
tb/shlg_checker.sv
tb/squared_hinge_loss_gradient_tb.sv
